// ----- rtl/core/rsf_pkg.sv -----
// Shared types and arithmetic for the recursive smoothing filter.
// Holds the request/response payload structs and the floor divide-by-three helper.
// No dependencies.
package rsf_pkg;

   // Input transaction payload.
   typedef struct packed {
      logic signed [15:0] sample;
      logic               end_of_sequence;
   } req_type;

   // Output transaction payload.
   typedef struct packed {
      logic signed [23:0] smoothed;
      logic               final_of_sequence;
   } rsp_type;

   // Width of the widest scaled numerator before division.
   localparam int NUM_W = 27;

   // Offset that makes any numerator non-negative and is itself a multiple of three.
   localparam logic [NUM_W:0] DIV3_OFFSET = 28'hC000000;

   // ceil(2^29 / 3); exact for every non-negative operand below 2^28.
   localparam logic [NUM_W:0] DIV3_RECIP = 28'd178956971;
   localparam int DIV3_SHIFT = 29;

   // Floor division of a signed numerator by three.
   // The offset adds 2^26 to the quotient, which vanishes in the low 24 bits.
   function automatic logic signed [23:0] div3_floor(input logic signed [NUM_W-1:0] num);
      logic [NUM_W:0]     biased;
      logic [2*NUM_W+1:0] prod;
      begin
         biased = {num[NUM_W-1], num} + DIV3_OFFSET;
         prod   = (2*NUM_W+2)'(biased) * (2*NUM_W+2)'(DIV3_RECIP);
         return prod[DIV3_SHIFT+23:DIV3_SHIFT];
      end
   endfunction

endpackage

// ----- rtl/core/recursive_smoothing_filter.sv -----
// Recursive three-tap smoothing filter, top level.
// Depends on rsf_pkg for the payload structs and the divide-by-three helper.
//
// Usage:
// The req channel takes one signed 16-bit sample per transaction, with
// end_of_sequence marking the last sample of a sequence. The rsp channel
// returns smoothed values in Q15.8 with final_of_sequence on the last one.
// The first sample of a longer sequence is held and gives no result; every
// later sample gives the result for the sample before it, queued when the
// sample is accepted. The final sample gives two results: the held sample's
// output, queued on acceptance, and then the sequence's final output from a
// registered stage, during which the req channel is not ready. A one-sample
// sequence gives a single result. Throughput is one sample per cycle while
// req_ready is high, i.e. not while a final output waits or the queue is
// full. The one shared reciprocal multiplier for division by three sets the
// cycle's logic depth. Results wait in a two-entry output queue, so samples
// keep being accepted while the receiver stalls until the queue is full.
// Synchronous reset empties the queue and discards any held sample.
module recursive_smoothing_filter (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  rsf_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsf_pkg::rsp_type rsp_data
);

   // Filter state.
   logic signed [15:0] held_ff, held_in;
   logic signed [23:0] prev_ff, prev_in;
   logic               pending_ff, pending_in;
   logic               first_ff, first_in;

   // Final output waiting for its turn at the divider.
   logic               sec_valid_ff, sec_valid_in;
   logic signed [23:0] sec_y_ff, sec_y_in;
   logic signed [15:0] sec_s_ff, sec_s_in;

   // Two-entry output queue.
   rsf_pkg::rsp_type   queue_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   logic               accept;
   logic               item_push;
   logic               sec_push;
   logic               push;
   logic               pop;
   logic signed [rsf_pkg::NUM_W-1:0] s256;
   logic signed [rsf_pkg::NUM_W-1:0] s512;
   logic signed [rsf_pkg::NUM_W-1:0] h512;
   logic signed [rsf_pkg::NUM_W-1:0] prev_ext;
   logic signed [rsf_pkg::NUM_W-1:0] sec_num;
   logic signed [rsf_pkg::NUM_W-1:0] inner_num;
   logic signed [rsf_pkg::NUM_W-1:0] div_num;
   logic signed [23:0] div_q;
   logic signed [23:0] inner_y;
   rsf_pkg::rsp_type   push_data;

   // Handshakes.
   assign req_ready = !sec_valid_ff && (count_ff != 2'd2);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign item_push = accept && (pending_ff || req_data.end_of_sequence);
   assign sec_push  = sec_valid_ff && (count_ff != 2'd2);
   assign push      = item_push || sec_push;

   // Scaled operands, all sign-extended to the numerator width.
   assign s256     = {{3{req_data.sample[15]}}, req_data.sample, 8'b0};
   assign s512     = {{2{req_data.sample[15]}}, req_data.sample, 9'b0};
   assign h512     = {{2{held_ff[15]}}, held_ff, 9'b0};
   assign prev_ext = {{3{prev_ff[23]}}, prev_ff};
   assign sec_num  = {{3{sec_y_ff[23]}}, sec_y_ff}
                   + {{2{sec_s_ff[15]}}, sec_s_ff, 9'b0};
   assign inner_num = prev_ext + h512 + s256;
   assign inner_y   = inner_num[25:2];

   // The divider is shared: the final output uses it only while req is stalled.
   always_comb begin
      priority if (sec_valid_ff) begin
         div_num = sec_num;
      end else if (pending_ff) begin
         div_num = h512 + s256;
      end else begin
         div_num = s512;
      end
   end
   assign div_q = rsf_pkg::div3_floor(div_num);

   // Value pushed into the output queue.
   always_comb begin
      if (sec_valid_ff) begin
         push_data.smoothed          = div_q;
         push_data.final_of_sequence = 1'b1;
      end else if (pending_ff && !first_ff) begin
         push_data.smoothed          = inner_y;
         push_data.final_of_sequence = 1'b0;
      end else begin
         push_data.smoothed          = div_q;
         push_data.final_of_sequence = !pending_ff;
      end
   end

   // Filter state and final-output stage updates.
   always_comb begin
      held_in      = held_ff;
      prev_in      = prev_ff;
      pending_in   = pending_ff;
      first_in     = first_ff;
      sec_valid_in = sec_valid_ff;
      sec_y_in     = sec_y_ff;
      sec_s_in     = sec_s_ff;
      if (sec_push) begin
         sec_valid_in = 1'b0;
      end
      if (accept) begin
         if (!pending_ff) begin
            if (!req_data.end_of_sequence) begin
               held_in    = req_data.sample;
               pending_in = 1'b1;
               first_in   = 1'b1;
            end
         end else begin
            prev_in = push_data.smoothed;
            if (req_data.end_of_sequence) begin
               sec_valid_in = 1'b1;
               sec_y_in     = push_data.smoothed;
               sec_s_in     = req_data.sample;
               pending_in   = 1'b0;
               first_in     = 1'b0;
            end else begin
               held_in  = req_data.sample;
               first_in = 1'b0;
            end
         end
      end
   end

   // Output queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         first_ff     <= 1'b0;
         sec_valid_ff <= 1'b0;
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         count_ff     <= 2'd0;
         held_ff      <= '0;
         prev_ff      <= '0;
      end else begin
         pending_ff   <= pending_in;
         first_ff     <= first_in;
         sec_valid_ff <= sec_valid_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         held_ff      <= held_in;
         prev_ff      <= prev_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sec_y_ff <= sec_y_in;
      sec_s_ff <= sec_s_in;
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   // The queue never takes a result while it is full.
   assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (count_ff == 2'd2)))
      else $error("output queue overflow");

   // A final sample after held samples schedules the final output.
   assert property (@(posedge clock) disable iff (reset)
      (accept && pending_ff && req_data.end_of_sequence) |=> sec_valid_ff)
      else $error("final output not scheduled");

   // A pending final output means the sequence has already ended.
   assert property (@(posedge clock) disable iff (reset)
      !(sec_valid_ff && pending_ff))
      else $error("final output pending while a sample is held");

   // The first-sample flag only applies to a held sample.
   assert property (@(posedge clock) disable iff (reset)
      first_ff |-> pending_ff)
      else $error("first flag set with nothing held");
`endif

endmodule
